### rtl/lwbs_pkg.sv
// Shared types and constants for the longest bounded-spread window block.
package lwbs_pkg;

   localparam int SAMPLE_W        = 30;
   localparam int LEN_W           = 11;
   localparam int MAX_LEN_DEFAULT = 1024;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH   = CSR_IDX_W'(1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] best_length;
      logic             found;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic pop;
      logic push;
      logic advance;
      logic finish;
      logic set_overflow;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic max_pop;
      logic min_pop;
      logic over_limit;
      logic last;
      logic rsp_busy;
   } status_type;

endpackage

### rtl/lwbs_ctrl.sv
// Sequencer for request intake, queue maintenance, window shrink and result issue.
module lwbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_stall,
   input  lwbs_pkg::status_type  status,
   output lwbs_pkg::cmd_type     cmd
);
   import lwbs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_POP    = 5'b00010,
      S_SETTLE = 5'b00100,
      S_SHRINK = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!status.full) begin
                  cmd.take = 1'b1;
                  state_in = S_POP;
               end else begin
                  cmd.set_overflow = 1'b1;
                  state_in = req_last ? S_EMIT : S_IDLE;
               end
            end
         end
         S_POP: begin
            cmd.pop = 1'b1;
            if (!status.max_pop && !status.min_pop) begin
               cmd.push = 1'b1;
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_SHRINK;
         end
         S_SHRINK: begin
            if (status.over_limit) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = status.last ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/lwbs_dp.sv
// Datapath: monotonic max/min queues in memory, window pointers, best length, result register.
module lwbs_dp #(
   parameter int MAX_LEN = lwbs_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lwbs_pkg::cmd_type                 cmd,
   output lwbs_pkg::status_type              status,
   input  logic [lwbs_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lwbs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   input  logic [lwbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lwbs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lwbs_pkg::*;

   localparam int IDXW = $clog2(MAX_LEN);
   localparam int CNTW = $clog2(MAX_LEN + 1);
   localparam int ENTW = IDXW + SAMPLE_W;
   localparam int CMPW = (CNTW > LEN_W) ? CNTW : LEN_W;

   // queue entry: {sample index, sample value}
   logic [ENTW-1:0] max_q_mem [MAX_LEN];
   logic [ENTW-1:0] min_q_mem [MAX_LEN];

   logic [SAMPLE_W-1:0] spread_ff;
   logic [LEN_W-1:0]    min_len_ff;
   logic [SAMPLE_W-1:0] v_ff;
   logic                last_ff;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [IDXW-1:0]     ws_ff, ws_in;
   logic [CNTW-1:0]     best_ff, best_in;
   logic                ovf_ff, ovf_in;
   logic [CNTW-1:0]     max_head_ff, max_head_in, max_tail_ff, max_tail_in;
   logic [CNTW-1:0]     min_head_ff, min_head_in, min_tail_ff, min_tail_in;
   logic [ENTW-1:0]     max_rt_ff, max_rh_ff, min_rt_ff, min_rh_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic [CNTW-1:0]     max_tm1, min_tm1;
   logic [CNTW-1:0]     win_len;
   logic [ENTW-1:0]     push_entry;
   logic [SAMPLE_W-1:0] spread;
   logic                max_hpop, min_hpop;
   logic [CMPW-1:0]     best_ext;

   assign spread     = max_rh_ff[SAMPLE_W-1:0] - min_rh_ff[SAMPLE_W-1:0];
   assign push_entry = {count_ff[IDXW-1:0], v_ff};
   assign win_len    = count_ff + CNTW'(1) - CNTW'(ws_ff);
   assign max_hpop   = (max_head_ff < max_tail_ff) && (max_rh_ff[ENTW-1:SAMPLE_W] <= ws_ff);
   assign min_hpop   = (min_head_ff < min_tail_ff) && (min_rh_ff[ENTW-1:SAMPLE_W] <= ws_ff);
   assign best_ext   = CMPW'(best_ff);

   always_comb begin
      status.full       = (count_ff == CNTW'(MAX_LEN));
      status.max_pop    = (max_tail_ff > max_head_ff) && (max_rt_ff[SAMPLE_W-1:0] <= v_ff);
      status.min_pop    = (min_tail_ff > min_head_ff) && (min_rt_ff[SAMPLE_W-1:0] >= v_ff);
      status.over_limit = (spread > spread_ff);
      status.last       = last_ff;
      status.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      max_tail_in = max_tail_ff;
      min_tail_in = min_tail_ff;
      max_head_in = max_head_ff;
      min_head_in = min_head_ff;
      ws_in       = ws_ff;
      count_in    = count_ff;
      best_in     = best_ff;
      ovf_in      = ovf_ff;
      if (cmd.pop && status.max_pop) begin
         max_tail_in = max_tail_ff - CNTW'(1);
      end
      if (cmd.pop && status.min_pop) begin
         min_tail_in = min_tail_ff - CNTW'(1);
      end
      if (cmd.push) begin
         max_tail_in = max_tail_ff + CNTW'(1);
         min_tail_in = min_tail_ff + CNTW'(1);
      end
      if (cmd.advance) begin
         ws_in = ws_ff + IDXW'(1);
         if (max_hpop) begin
            max_head_in = max_head_ff + CNTW'(1);
         end
         if (min_hpop) begin
            min_head_in = min_head_ff + CNTW'(1);
         end
      end
      if (cmd.finish) begin
         count_in = count_ff + CNTW'(1);
         if (win_len > best_ff) begin
            best_in = win_len;
         end
      end
      if (cmd.set_overflow) begin
         ovf_in = 1'b1;
      end
      if (cmd.emit) begin
         max_tail_in = '0;
         min_tail_in = '0;
         max_head_in = '0;
         min_head_in = '0;
         ws_in       = '0;
         count_in    = '0;
         best_in     = '0;
         ovf_in      = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign max_tm1 = max_tail_in - CNTW'(1);
   assign min_tm1 = min_tail_in - CNTW'(1);

   // tail ports track the entry below the tail, head ports the head entry
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         max_q_mem[max_tail_ff[IDXW-1:0]] <= push_entry;
         min_q_mem[min_tail_ff[IDXW-1:0]] <= push_entry;
      end
      max_rt_ff <= max_q_mem[max_tm1[IDXW-1:0]];
      min_rt_ff <= min_q_mem[min_tm1[IDXW-1:0]];
      max_rh_ff <= max_q_mem[max_head_in[IDXW-1:0]];
      min_rh_ff <= min_q_mem[min_head_in[IDXW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         v_ff    <= req_sample;
         last_ff <= req_last;
      end
      if (cmd.emit) begin
         rsp_data_ff.best_length <= best_ext[LEN_W-1:0];
         rsp_data_ff.found       <= (best_ext >= CMPW'(min_len_ff));
         rsp_data_ff.overflow    <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_ff    <= '0;
         min_len_ff   <= LEN_W'(1);
         count_ff     <= '0;
         ws_ff        <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         max_head_ff  <= '0;
         max_tail_ff  <= '0;
         min_head_ff  <= '0;
         min_tail_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SPREAD_LIMIT: spread_ff  <= csr_wdata[SAMPLE_W-1:0];
               CSR_MIN_LENGTH:   min_len_ff <= csr_wdata[LEN_W-1:0];
               default: begin
               end
            endcase
         end
         count_ff     <= count_in;
         ws_ff        <= ws_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         max_head_ff  <= max_head_in;
         max_tail_ff  <= max_tail_in;
         min_head_ff  <= min_head_in;
         min_tail_ff  <= min_tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/longest_window_bounded_spread.sv
// Top level: longest run of samples whose max minus min stays within a limit.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| req_data  (sample, last)
//  rsp     | out       | rsp_valid/rsp_stall| rsp_data  (best_length, found, overflow)
//  csr     | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// One request at a time: intake, tail-pop steps (both queues pop in the same step), a settle
// step, then window-start advances; each step waits on a registered queue-memory read.
// A last request then loads the result register. Requests past MAX_LEN only set overflow.
// Reset is synchronous; no clearing pass. A held result does not block intake; only a
// second result waits for the first to leave.
module longest_window_bounded_spread #(
   parameter int MAX_LEN = lwbs_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lwbs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lwbs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lwbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lwbs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lwbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lwbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lwbs_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_data.sample),
      .req_last   (req_data.last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

`ifndef ASSERT_OFF
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("result loaded while previous result still held");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.push, cmd.advance, cmd.finish, cmd.set_overflow, cmd.emit}))
      else $error("conflicting datapath commands");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !status.full) |=> req_stall)
      else $error("request taken while previous request still in work");
`endif

endmodule
